>>> rtl/core/daa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// daa_pkg
// Shared types and constants for the distinct average aggregator.
// ----------------------------------------------------------------------------
package daa_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int VALUE_WIDTH_DEF = 48;

  localparam int SUM_W   = 64;
  localparam int COUNT_W = 16;
  localparam int FRAC_W  = 16;
  localparam int QUO_W   = SUM_W + FRAC_W;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SUM_W-1:0]   SUM_NEG_MAX = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [SUM_W-1:0]   SUM_POS_MAX = {1'b0, {(SUM_W-1){1'b1}}};

endpackage
`default_nettype wire

>>> rtl/core/daa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// daa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module daa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/core/distinct_average_aggregator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// distinct_average_aggregator
// Running AVG aggregate with optional DISTINCT filtering over a value table.
// ----------------------------------------------------------------------------
// Add: S_ADD updates sum and count directly without distinct mode; in distinct mode the
// table scan reads one RAM entry per cycle, then inserts unless it finds a duplicate.
// Read runs an 80-step radix-2 divider if the count is nonzero; clear and others finish.
// One request at a time; busy is high until the done strobe.
// The receiver cannot stall: results show for exactly one cycle on done.
// Synchronous reset clears sum, count, fill, flags and mode; table RAM is not cleared.
module distinct_average_aggregator #(
  parameter int TABLE_DEPTH = daa_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = daa_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic signed [47:0] value,
  input  wire logic        is_null,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  output logic             done,
  output logic             has_average,
  output logic signed [63:0] average,
  output logic [15:0]      counted_values,
  output logic             was_duplicate,
  output logic             table_full,
  output logic             sum_saturated
);

  localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
  localparam int SUM_W  = daa_pkg::SUM_W;
  localparam int CNT_W  = daa_pkg::COUNT_W;
  localparam int QUO_W  = daa_pkg::QUO_W;
  localparam int STEP_W = $clog2(QUO_W + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_ADD, S_SCAN, S_INSERT, S_DIV, S_DIVFIN, S_FINISH
  } state_t;

  state_t state;

  logic                   distinct_mode;
  logic [SUM_W-1:0]       running_sum;
  logic [CNT_W-1:0]       value_count;
  logic [FILL_W-1:0]      seen_fill;
  logic                   sum_limit_hit;

  logic [VALUE_WIDTH-1:0] v_reg;
  logic                   dup;
  logic                   full;
  logic [SUM_W-1:0]       avg;

  logic [FILL_W-1:0]      scan_idx;
  logic                   cmp_valid;

  logic [QUO_W-1:0]       quo;
  logic [CNT_W-1:0]       rem;
  logic [STEP_W-1:0]      step;
  logic                   neg;

  logic                   ram_we;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  logic [SUM_W-1:0]       v64;
  logic [SUM_W-1:0]       sum_add;
  logic                   sum_ovf;
  logic [SUM_W-1:0]       sum_next;
  logic [CNT_W:0]         rem_sh;
  logic [CNT_W:0]         cnt_ext;
  logic                   rem_ge;
  logic [SUM_W-1:0]       limit;
  logic [SUM_W-1:0]       q_clamp;

  assign v64     = {{(SUM_W-VALUE_WIDTH){v_reg[VALUE_WIDTH-1]}}, v_reg};
  assign sum_add = running_sum + v64;
  assign sum_ovf = (running_sum[SUM_W-1] == v64[SUM_W-1]) &&
                   (sum_add[SUM_W-1] != running_sum[SUM_W-1]);
  assign sum_next = !sum_ovf ? sum_add :
                    (running_sum[SUM_W-1] ? daa_pkg::SUM_NEG_MAX : daa_pkg::SUM_POS_MAX);

  assign rem_sh  = {rem, quo[QUO_W-1]};
  assign cnt_ext = {1'b0, value_count};
  assign rem_ge  = rem_sh >= cnt_ext;

  assign limit   = neg ? daa_pkg::SUM_NEG_MAX : daa_pkg::SUM_POS_MAX;
  assign q_clamp = ((|quo[QUO_W-1:SUM_W]) || (quo[SUM_W-1:0] > limit)) ? limit
                                                                       : quo[SUM_W-1:0];

  assign ram_we = (state == S_INSERT) && (seen_fill < FILL_W'(TABLE_DEPTH));
  assign busy   = (state != S_IDLE);

  daa_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(TABLE_DEPTH)
  ) u_seen_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(seen_fill[AW-1:0]),
    .wdata(v_reg),
    .raddr(scan_idx[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      distinct_mode <= 1'b0;
      running_sum   <= '0;
      value_count   <= '0;
      seen_fill     <= '0;
      sum_limit_hit <= 1'b0;
      cmp_valid     <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        distinct_mode <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            v_reg <= value[VALUE_WIDTH-1:0];
            dup   <= 1'b0;
            full  <= 1'b0;
            avg   <= '0;
            neg   <= running_sum[SUM_W-1];
            quo   <= {(running_sum[SUM_W-1] ? -running_sum : running_sum),
                      {daa_pkg::FRAC_W{1'b0}}};
            rem   <= '0;
            step  <= '0;
            priority if (req_type == daa_pkg::REQ_ADD && !is_null) begin
              state <= S_ADD;
            end else if (req_type == daa_pkg::REQ_READ && value_count != '0) begin
              state <= S_DIV;
            end else if (req_type == daa_pkg::REQ_CLEAR) begin
              running_sum   <= '0;
              value_count   <= '0;
              seen_fill     <= '0;
              sum_limit_hit <= 1'b0;
              state         <= S_FINISH;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_ADD: begin
          if (distinct_mode) begin
            scan_idx  <= '0;
            cmp_valid <= 1'b0;
            state     <= S_SCAN;
          end else begin
            running_sum <= sum_next;
            if (sum_ovf) sum_limit_hit <= 1'b1;
            if (value_count != daa_pkg::COUNT_MAX) value_count <= value_count + 1'b1;
            state <= S_FINISH;
          end
        end
        S_SCAN: begin
          // The entry read last cycle is compared while the next is read.
          if (cmp_valid && ram_rdata == v_reg) begin
            dup       <= 1'b1;
            cmp_valid <= 1'b0;
            state     <= S_FINISH;
          end else if (scan_idx < seen_fill) begin
            scan_idx  <= scan_idx + 1'b1;
            cmp_valid <= 1'b1;
          end else if (cmp_valid) begin
            cmp_valid <= 1'b0;
          end else begin
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          if (seen_fill < FILL_W'(TABLE_DEPTH)) begin
            seen_fill   <= seen_fill + 1'b1;
            running_sum <= sum_next;
            if (sum_ovf) sum_limit_hit <= 1'b1;
            if (value_count != daa_pkg::COUNT_MAX) value_count <= value_count + 1'b1;
          end else begin
            full <= 1'b1;
          end
          state <= S_FINISH;
        end
        S_DIV: begin
          rem  <= rem_ge ? CNT_W'(rem_sh - cnt_ext) : rem_sh[CNT_W-1:0];
          quo  <= {quo[QUO_W-2:0], rem_ge};
          step <= step + 1'b1;
          if (step == STEP_W'(QUO_W - 1)) begin
            state <= S_DIVFIN;
          end
        end
        S_DIVFIN: begin
          avg   <= neg ? -q_clamp : q_clamp;
          state <= S_FINISH;
        end
        S_FINISH: begin
          done           <= 1'b1;
          has_average    <= (value_count != '0);
          average        <= avg;
          counted_values <= value_count;
          was_duplicate  <= dup;
          table_full     <= full;
          sum_saturated  <= sum_limit_hit;
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
